/* hdl/tsc_pkg.sv */
// Shared constants, types and codes for the tempo sync pulse clock.
`timescale 1ns / 1ps
package tsc_pkg;

  // Phase accumulator and pulse timing
  localparam int PHASE_BITS = 32;
  localparam int PULSE_MS   = 15;
  localparam int CNT_W      = $clog2(PHASE_BITS);

  // Field and register widths
  localparam int SR_W       = 18;
  localparam int TEMPO_W    = 20;
  localparam int TPQ_W      = 7;
  localparam int LEVEL_W    = 15;
  localparam int PROF_W     = 2;
  localparam int KIND_W     = 2;
  localparam int PULSE_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Increment divide: tempo * ticks over 60000 * sample rate
  localparam int MS_PER_MIN = 60000;
  localparam int MS_PER_S   = 1000;
  localparam int DIVIDEND_W = TEMPO_W + TPQ_W;
  localparam int DIVISOR_W  = SR_W + 16;

  // Pulse length: sample rate * PULSE_MS / 1000 by reciprocal and one correction
  localparam int PLEN_SHIFT  = 32;
  localparam int PLEN_PROD_W = SR_W + PLEN_SHIFT;
  localparam int PLEN_X_W    = SR_W + 7;
  localparam logic [PLEN_SHIFT-1:0] PLEN_RECIP =
    PLEN_SHIFT'((64'(PULSE_MS) << PLEN_SHIFT) / 64'(MS_PER_S));
  localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

  // Reset values of the registers
  localparam logic [SR_W-1:0]    SR_RST    = SR_W'(44100);
  localparam logic [TEMPO_W-1:0] TEMPO_RST = TEMPO_W'(120000);
  localparam logic [TPQ_W-1:0]   TPQ_RST   = TPQ_W'(4);
  localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(29490);

  // Sync profiles
  localparam logic [PROF_W-1:0] PROF_OFF   = 2'd0;
  localparam logic [PROF_W-1:0] PROF_EVEN  = 2'd1;
  localparam logic [PROF_W-1:0] PROF_EVERY = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_RATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TEMPO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_QTR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PROFILE  = 3'd4;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    OP_STEP  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TEMPO = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_STEP
  } div_state_e;

  typedef struct packed {
    op_e                op;
    logic               rephase;
    logic [TEMPO_W-1:0] tempo;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic               start;
    logic [TEMPO_W-1:0] tempo;
    logic [TPQ_W-1:0]   tpq;
    logic [SR_W-1:0]    sr;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/tsc_front.sv */
// Input side: takes beats, classifies them and pushes commands into the queue.
`timescale 1ns / 1ps
module tsc_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tsc_pkg::KIND_W-1:0]    kind_i,
  input  logic                          rephase_i,
  input  logic [tsc_pkg::TEMPO_W-1:0]   tempo_value_i,
  input  tsc_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output tsc_pkg::item_t                item_o
);
  import tsc_pkg::*;

  op_e  op;
  logic drop;

  // Decode the kind; a tempo change to zero never reaches the back end.
  assign op   = op_e'(kind_i);
  assign drop = (op == OP_TEMPO) && (tempo_value_i == '0);

  assign s_axis_tready_o = !q_stat_i.full;
  assign push_o          = s_axis_tvalid_i && !q_stat_i.full && !drop;

  assign item_o = '{op: op, rephase: rephase_i, tempo: tempo_value_i};

endmodule

/* hdl/tsc_queue.sv */
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module tsc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tsc_pkg::item_t   item_i,
  input  logic             pop_i,
  output tsc_pkg::item_t   item_o,
  output tsc_pkg::q_stat_t stat_o
);
  import tsc_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign item_o       = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hdl/tsc_div.sv */
// Bit-serial restoring divider that produces the phase increment.
`timescale 1ns / 1ps
module tsc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsc_pkg::div_req_t              req_i,
  output tsc_pkg::div_stat_t             stat_o,
  output logic [tsc_pkg::PHASE_BITS-1:0] quot_o
);
  import tsc_pkg::*;

  div_state_e            state_q, state_d;
  logic [DIVIDEND_W-1:0] a_q;
  logic [DIVISOR_W-1:0]  d_q, r_q;
  logic [PHASE_BITS-1:0] quot_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  done_q;

  logic [DIVISOR_W:0]    r_shift, r_sub;
  logic                  r_ge, a_ge, last;
  logic                  load_rem, do_step, saturate, finish;

  // One restoring step on the partial remainder.
  assign r_shift = {r_q, 1'b0};
  assign r_sub   = r_shift - {1'b0, d_q};
  assign r_ge    = (r_shift >= {1'b0, d_q});
  assign a_ge    = (DIVISOR_W'(a_q) >= d_q);
  assign last    = (cnt_q == CNT_W'(PHASE_BITS - 1));

  // Next state; a new request restarts the divide from its operands.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) state_d = DIV_CHECK;
      end
      DIV_CHECK: begin
        if (req_i.start) state_d = DIV_CHECK;
        else if (a_ge)   state_d = DIV_IDLE;
        else             state_d = DIV_STEP;
      end
      DIV_STEP: begin
        if (req_i.start) state_d = DIV_CHECK;
        else if (last)   state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    load_rem = 1'b0;
    do_step  = 1'b0;
    saturate = 1'b0;
    unique case (state_q)
      DIV_CHECK: begin
        load_rem = !req_i.start && !a_ge;
        saturate = !req_i.start && a_ge;
      end
      DIV_STEP: begin
        do_step = !req_i.start;
      end
      default: begin
        load_rem = 1'b0;
      end
    endcase
    finish = saturate || (do_step && last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
    end
  end

  // Operands, remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= DIVIDEND_W'(req_i.tempo) * DIVIDEND_W'(req_i.tpq);
      d_q   <= DIVISOR_W'(req_i.sr) * DIVISOR_W'(MS_PER_MIN);
      cnt_q <= '0;
    end
    if (load_rem) begin
      r_q    <= DIVISOR_W'(a_q);
      quot_q <= '0;
    end
    if (saturate) begin
      quot_q <= '1;
    end
    if (do_step) begin
      r_q    <= r_ge ? r_sub[DIVISOR_W-1:0] : r_shift[DIVISOR_W-1:0];
      quot_q <= {quot_q[PHASE_BITS-2:0], r_ge};
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  assign stat_o.busy = req_i.start || (state_q != DIV_IDLE) || done_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

/* hdl/tsc_back.sv */
// Back end: registers, phase accumulator, pulse timer and the output register.
`timescale 1ns / 1ps
module tsc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  tsc_pkg::q_stat_t                q_stat_i,
  input  tsc_pkg::item_t                  q_item_i,
  output logic                            q_pop_o,
  output tsc_pkg::div_req_t               div_req_o,
  input  tsc_pkg::div_stat_t              div_stat_i,
  input  logic [tsc_pkg::PHASE_BITS-1:0]  div_quot_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic                            m_tick_o,
  output logic [tsc_pkg::LEVEL_W-1:0]     m_pulse_o
);
  import tsc_pkg::*;

  // Configuration
  logic [SR_W-1:0]    sr_q;
  logic [TPQ_W-1:0]   tpq_q;
  logic [LEVEL_W-1:0] level_q;
  logic [PROF_W-1:0]  prof_q;
  logic [TEMPO_W-1:0] tempo_q;
  logic               cfg_hit, prof_wr, req_q;

  // Run state
  logic                  running_q, pending_q, parity_q;
  logic [PHASE_BITS-1:0] phase_q, incr_q;
  logic [PULSE_W-1:0]    pulse_left_q, plen_q;

  // Output register
  logic               out_valid_q, out_tick_q;
  logic [LEVEL_W-1:0] out_pulse_q;

  // Pulse length pipeline
  logic [PLEN_PROD_W-1:0] plen_prod;
  logic [SR_W-1:0]        plen_est_q, plen_fix;
  logic [PLEN_X_W-1:0]    plen_x, plen_back, plen_rem;
  logic [PULSE_W-1:0]     plen_d;

  // Step evaluation
  logic [PHASE_BITS:0]   sum;
  logic                  step_tick, pulse_start, pulse_on;
  logic [PULSE_W-1:0]    pl_cur;
  logic                  out_free, stall, tempo_take, step_pop;

  // Which register a write hits.
  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_idx_i)
      REG_AUDIO_RATE, REG_INITIAL_TEMPO, REG_TICKS_PER_QTR,
      REG_PULSE_LEVEL, REG_SYNC_PROFILE: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end
  assign prof_wr = cfg_we_i && (cfg_idx_i == REG_SYNC_PROFILE);

  // Register file; a zero write restores the reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q    <= SR_RST;
      tpq_q   <= TPQ_RST;
      level_q <= LEVEL_RST;
      prof_q  <= PROF_OFF;
      tempo_q <= TEMPO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AUDIO_RATE: begin
          sr_q <= (cfg_data_i[SR_W-1:0] != '0) ? cfg_data_i[SR_W-1:0] : SR_RST;
        end
        REG_INITIAL_TEMPO: begin
          tempo_q <= (cfg_data_i[TEMPO_W-1:0] != '0) ? cfg_data_i[TEMPO_W-1:0] : TEMPO_RST;
        end
        REG_TICKS_PER_QTR: begin
          tpq_q <= (cfg_data_i[TPQ_W-1:0] != '0) ? cfg_data_i[TPQ_W-1:0] : TPQ_RST;
        end
        REG_PULSE_LEVEL: begin
          level_q <= (cfg_data_i[LEVEL_W-1:0] != '0) ? cfg_data_i[LEVEL_W-1:0] : LEVEL_RST;
        end
        REG_SYNC_PROFILE: begin
          prof_q <= (cfg_data_i[PROF_W-1:0] == PROF_EVEN ||
                     cfg_data_i[PROF_W-1:0] == PROF_EVERY) ? cfg_data_i[PROF_W-1:0]
                                                           : PROF_OFF;
        end
        default: begin
          prof_q <= prof_q;
        end
      endcase
    end else if (tempo_take) begin
      tempo_q <= q_item_i.tempo;
    end
  end

  // A recompute is requested after reset, any write to a known register and any real tempo change.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b1;
    end else begin
      req_q <= cfg_hit || tempo_take;
    end
  end

  assign div_req_o = '{start: req_q, tempo: tempo_q, tpq: tpq_q, sr: sr_q};

  always_ff @(posedge clk_i) begin
    if (div_stat_i.done) begin
      incr_q <= div_quot_i;
    end
  end

  // Pulse length: reciprocal estimate, then one correction step.
  assign plen_prod = PLEN_PROD_W'(sr_q) * PLEN_PROD_W'(PLEN_RECIP);
  assign plen_x    = PLEN_X_W'(sr_q) * PLEN_X_W'(PULSE_MS);
  assign plen_back = PLEN_X_W'(plen_est_q) * PLEN_X_W'(MS_PER_S);
  assign plen_rem  = plen_x - plen_back;
  assign plen_fix  = plen_est_q + SR_W'(plen_rem >= PLEN_X_W'(MS_PER_S));
  assign plen_d    = (plen_fix > SR_W'(PULSE_MAX)) ? PULSE_MAX : plen_fix[PULSE_W-1:0];

  always_ff @(posedge clk_i) begin
    plen_est_q <= plen_prod[PLEN_SHIFT +: SR_W];
    plen_q     <= plen_d;
  end

  // Queue pop: hold while the increment is stale or the output slot is taken.
  assign out_free   = !out_valid_q || m_ready_i;
  assign stall      = req_q || div_stat_i.busy;
  assign q_pop_o    = q_stat_i.valid && !stall && (q_item_i.op != OP_STEP || out_free);
  assign step_pop   = q_pop_o && (q_item_i.op == OP_STEP);
  assign tempo_take = q_pop_o && (q_item_i.op == OP_TEMPO) && (q_item_i.tempo != tempo_q);

  // Evaluate one sample step.
  assign sum         = {1'b0, phase_q} + {1'b0, incr_q};
  assign step_tick   = pending_q || sum[PHASE_BITS];
  assign pulse_start = step_tick &&
                       ((prof_q == PROF_EVERY) || ((prof_q == PROF_EVEN) && !parity_q));
  assign pl_cur      = pulse_start ? plen_q : pulse_left_q;
  assign pulse_on    = (pl_cur != '0);

  // Run state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      pending_q    <= 1'b0;
      parity_q     <= 1'b0;
      phase_q      <= '0;
      pulse_left_q <= '0;
    end else begin
      if (prof_wr) begin
        pulse_left_q <= '0;
      end
      if (q_pop_o) begin
        unique case (q_item_i.op)
          OP_START: begin
            running_q <= 1'b1;
            if (q_item_i.rephase) begin
              phase_q      <= '0;
              parity_q     <= 1'b0;
              pulse_left_q <= '0;
              pending_q    <= 1'b1;
            end
          end
          OP_STOP: begin
            running_q    <= 1'b0;
            pending_q    <= 1'b0;
            pulse_left_q <= '0;
          end
          OP_TEMPO: begin
            running_q <= running_q;
          end
          OP_STEP: begin
            if (running_q) begin
              pending_q <= 1'b0;
              if (!pending_q) begin
                phase_q <= sum[PHASE_BITS-1:0];
              end
              if (step_tick) begin
                parity_q <= !parity_q;
              end
              pulse_left_q <= pulse_on ? pl_cur - 1'b1 : '0;
            end
          end
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_pop) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_pop) begin
      out_tick_q  <= running_q && step_tick;
      out_pulse_q <= (running_q && pulse_on) ? level_q : '0;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_tick_o  = out_tick_q;
  assign m_pulse_o = out_pulse_q;

endmodule

/* hdl/tempo_sync_pulse_clock.sv */
// Top level of the tempo sync pulse clock.
`timescale 1ns / 1ps
// Per-sample tempo clock. Each beat on the input stream is a command: a sample step
// (which returns one beat with a tick flag and a pulse amplitude), start, stop or a
// tempo change (no output beat). A sample step passes through the queue and the output
// register, so steady sample traffic runs at one beat per clock while the output is
// ready and no recompute is pending. After reset, after every write to a known
// register and after every tempo change that alters the tempo, the phase increment is
// rebuilt by a bit-serial divider that retires one quotient bit per cycle. Commands wait
// in a two-entry queue during that time, so the input keeps accepting until it is full.
module tempo_sync_pulse_clock (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Command stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [23:0]                     s_axis_tdata_i,  // rephase, tempo_value
  input  logic [1:0]                      s_axis_tuser_i,  // kind
  // Sample result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [15:0]                     m_axis_tdata_o   // tick, pulse
);
  import tsc_pkg::*;

  q_stat_t                q_stat;
  item_t                  push_item, q_head;
  logic                   q_push, q_pop;
  div_req_t               div_req;
  div_stat_t              div_stat;
  logic [PHASE_BITS-1:0]  div_quot;
  logic                   out_tick;
  logic [LEVEL_W-1:0]     out_pulse;

  tsc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .kind_i          (s_axis_tuser_i[KIND_W-1:0]),
    .rephase_i       (s_axis_tdata_i[0]),
    .tempo_value_i   (s_axis_tdata_i[TEMPO_W:1]),
    .q_stat_i        (q_stat),
    .push_o          (q_push),
    .item_o          (push_item)
  );

  tsc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (q_head),
    .stat_o (q_stat)
  );

  tsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  tsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_stat_i   (q_stat),
    .q_item_i   (q_head),
    .q_pop_o    (q_pop),
    .div_req_o  (div_req),
    .div_stat_i (div_stat),
    .div_quot_i (div_quot),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_tick_o   (out_tick),
    .m_pulse_o  (out_pulse)
  );

  assign m_axis_tdata_o = {out_pulse, out_tick};

  // No command leaves the queue while the increment is being rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_stat.busy |-> !q_pop)
    else $error("queue popped during increment recompute");

  // A write to a known register starts a recompute.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i <= REG_SYNC_PROFILE) |=> div_stat.busy)
    else $error("register write did not start a recompute");

  // Every sample step popped from the queue shows up on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && (q_head.op == OP_STEP) |=> m_axis_tvalid_o)
    else $error("sample step lost on its way to the output");

endmodule
